// ===== rtl/dhkim_pkg.sv =====
// shared types and codes for the double hash key index map
`default_nettype none

package dhkim_pkg;

    // operation codes carried on the op field
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_DUP       = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_LOG2  = 2'd1;

    localparam int KEY_W   = 64;
    localparam int SHIFT_W = 5;
    localparam int ACT_W   = 4;
    localparam int FIELD_INDEX_W = 16;
    localparam int FIELD_COUNT_W = 11;

    // reset value of the active size register
    localparam logic [ACT_W-1:0] ACT_LOG2_RESET = 4'd8;

    // sequencer to probe unit
    typedef struct packed {
        logic load;
        logic advance;
    } probe_ctl_t;

    // probe unit back to sequencer
    typedef struct packed {
        logic empty;
        logic hit;
        logic last;
    } probe_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dhkim_slot_mem.sv =====
// single-port slot memory with registered read data
`default_nettype none

module dhkim_slot_mem
    import dhkim_pkg::*;
#(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 81
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/dhkim_probe_unit.sv =====
// probe address generator and slot key comparator
`default_nettype none

module dhkim_probe_unit
    import dhkim_pkg::*;
#(
    parameter int LOG2_SLOTS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire probe_ctl_t            ctl,
    input  wire logic [KEY_W-1:0]      load_key,
    input  wire logic [KEY_W-1:0]      cmp_key,
    input  wire logic [SHIFT_W-1:0]    key_shift,
    input  wire logic [ACT_W-1:0]      act_log2,
    input  wire logic                  rd_valid,
    input  wire logic [KEY_W-1:0]      rd_key,
    output logic      [LOG2_SLOTS-1:0] slot,
    output probe_sts_t                 sts
);

    localparam logic [4:0] MAX_ACT = 5'(LOG2_SLOTS);

    logic [4:0]            act_raw;
    logic [4:0]            act_c;
    logic [LOG2_SLOTS-1:0] mask;
    logic [KEY_W-1:0]      shifted;
    logic [LOG2_SLOTS-1:0] home;

    logic [LOG2_SLOTS-1:0] slot_reg, slot_next;
    logic [LOG2_SLOTS-1:0] step_reg, step_next;
    logic [LOG2_SLOTS-1:0] n_reg, n_next;

    // active size clamped into 1..LOG2_SLOTS
    assign act_raw = {1'b0, act_log2};
    always_comb
    begin
        if (act_raw == 5'd0)
        begin
            act_c = 5'd1;
        end
        else if (act_raw > MAX_ACT)
        begin
            act_c = MAX_ACT;
        end
        else
        begin
            act_c = act_raw;
        end
    end

    always_comb
    begin
        for (int b = 0; b < LOG2_SLOTS; b++)
        begin
            mask[b] = (5'(b) < act_c);
        end
    end

    assign shifted = load_key >> key_shift;
    assign home    = shifted[LOG2_SLOTS-1:0] & mask;

    always_comb
    begin
        slot_next = slot_reg;
        step_next = step_reg;
        n_next    = n_reg;
        if (ctl.load)
        begin
            slot_next = home;
            step_next = home | LOG2_SLOTS'(1);
            n_next    = '0;
        end
        else if (ctl.advance)
        begin
            slot_next = (slot_reg + step_reg) & mask;
            n_next    = n_reg + LOG2_SLOTS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            step_reg <= '0;
            n_reg    <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            step_reg <= step_next;
            n_reg    <= n_next;
        end
    end

    assign slot      = slot_reg;
    assign sts.empty = !rd_valid;
    assign sts.hit   = rd_valid && (rd_key == cmp_key);
    // every active slot has been probed
    assign sts.last  = (n_reg == mask);

endmodule

`default_nettype wire

// ===== rtl/double_hash_key_index_map_core.sv =====
// top level of the double hash key index map
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid / in_stall   | op, key, elem_index
//  out     | output    | out_valid / out_stall | status, found_index, count
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// lookup and insert take a read state and then a check state per probe, starting at the home
// slot; each probe is one read of the single-port slot memory
// clear sweeps every slot, one memory word cleared per cycle
// after reset a clearing pass over every slot runs before the first
// transaction is taken; config writes are taken throughout
// a finished result sits in the output register, so a stalled output does not
// hold off the next input transaction, only the result after it
`default_nettype none

module double_hash_key_index_map_core
    import dhkim_pkg::*;
#(
    parameter int LOG2_SLOTS = 10,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // config write port
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    // input transactions
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               op,
    input  wire logic [KEY_W-1:0]         key,
    input  wire logic [FIELD_INDEX_W-1:0] elem_index,
    // result transactions
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    status,
    output logic [FIELD_INDEX_W-1:0]      found_index,
    output logic [FIELD_COUNT_W-1:0]      count
);

    localparam int SLOTS  = 2**LOG2_SLOTS;
    localparam int CNT_W  = LOG2_SLOTS + 1;
    localparam int DATA_W = 1 + KEY_W + INDEX_BITS;

    // config registers
    logic [SHIFT_W-1:0] key_shift_reg;
    logic [ACT_W-1:0]   act_log2_reg;

    // sequencer
    state_t state_reg, state_next;
    logic   in_acc;
    logic   out_free;
    logic   probe_done;
    logic   clr_op_reg;

    // payload of the transaction in flight
    op_t                   op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [INDEX_BITS-1:0] elem_reg;
    logic [INDEX_BITS+FIELD_INDEX_W-1:0] elem_wide;
    logic [INDEX_BITS-1:0] elem_in;

    // result being built, and the output register
    status_t               res_status_reg;
    logic [INDEX_BITS-1:0] res_found_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [FIELD_INDEX_W-1:0] out_found_reg;
    logic [FIELD_COUNT_W-1:0] out_count_reg;
    logic [INDEX_BITS+FIELD_INDEX_W-1:0] found_wide;

    // entry count
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W+FIELD_COUNT_W-1:0] cnt_wide;

    // clearing sweep
    logic [LOG2_SLOTS-1:0] sweep_reg;
    logic                  sweep_last;

    // slot memory and probe unit
    probe_ctl_t            ctl;
    probe_sts_t            sts;
    logic [LOG2_SLOTS-1:0] probe_slot;
    logic                  mem_we;
    logic [LOG2_SLOTS-1:0] mem_addr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [DATA_W-1:0]     mem_rdata;
    logic                  rd_valid;
    logic [KEY_W-1:0]      rd_key;
    logic [INDEX_BITS-1:0] rd_elem;

    // element index stored at INDEX_BITS, zero-extended or truncated
    assign elem_wide = {{INDEX_BITS{1'b0}}, elem_index};
    assign elem_in   = elem_wide[INDEX_BITS-1:0];

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_shift_reg <= '0;
            act_log2_reg  <= ACT_LOG2_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_SHIFT: key_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_ACT_LOG2:  act_log2_reg  <= cfg_data[ACT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign in_acc     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign probe_done = sts.empty || sts.hit || sts.last;
    assign sweep_last = (sweep_reg == {LOG2_SLOTS{1'b1}});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op)
                        OP_CLEAR:             state_next = S_SWEEP;
                        OP_LOOKUP, OP_INSERT: state_next = S_READ;
                        default:              state_next = S_DONE;
                    endcase
                end
            end
            S_READ:  state_next = S_CHECK;
            S_CHECK:
            begin
                state_next = probe_done ? S_DONE : S_READ;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall    = 1'b1;
        ctl.load    = 1'b0;
        ctl.advance = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = probe_slot;
        case (state_reg)
            S_SWEEP:
            begin
                mem_we   = 1'b1;
                mem_addr = sweep_reg;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                ctl.load = in_acc;
            end
            S_CHECK:
            begin
                ctl.advance = !probe_done;
                mem_we      = (op_reg == OP_INSERT) && sts.empty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            clr_op_reg <= 1'b0;
            sweep_reg  <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SWEEP)
            begin
                sweep_reg <= sweep_reg + LOG2_SLOTS'(1);
            end
            if (in_acc)
            begin
                clr_op_reg <= (op == OP_CLEAR);
                if (op == OP_CLEAR)
                begin
                    cnt_reg <= '0;
                end
            end
            if (state_reg == S_CHECK && mem_we)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // payload and result building
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg         <= op_t'(op);
            key_reg        <= key;
            elem_reg       <= elem_in;
            res_status_reg <= STAT_OK;
            res_found_reg  <= '0;
        end
        else if (state_reg == S_CHECK)
        begin
            if (sts.empty)
            begin
                res_status_reg <= (op_reg == OP_INSERT) ? STAT_OK : STAT_NOT_FOUND;
            end
            else if (sts.hit)
            begin
                if (op_reg == OP_INSERT)
                begin
                    res_status_reg <= STAT_DUP;
                end
                else
                begin
                    res_status_reg <= STAT_OK;
                    res_found_reg  <= rd_elem;
                end
            end
            else if (sts.last)
            begin
                res_status_reg <= (op_reg == OP_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
            end
        end
    end

    // output register
    assign cnt_wide   = {{FIELD_COUNT_W{1'b0}}, cnt_reg};
    assign found_wide = {{FIELD_INDEX_W{1'b0}}, res_found_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= found_wide[FIELD_INDEX_W-1:0];
            out_count_reg  <= cnt_wide[FIELD_COUNT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_found_reg;
    assign count       = out_count_reg;

    // slot word: valid, key, element index
    assign mem_wdata = {(state_reg != S_SWEEP), key_reg, elem_reg};
    assign rd_valid  = mem_rdata[DATA_W-1];
    assign rd_key    = mem_rdata[DATA_W-2 -: KEY_W];
    assign rd_elem   = mem_rdata[INDEX_BITS-1:0];

    dhkim_slot_mem #(
        .ADDR_W (LOG2_SLOTS),
        .DATA_W (DATA_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    dhkim_probe_unit #(
        .LOG2_SLOTS (LOG2_SLOTS)
    ) u_probe_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .load_key  (key),
        .cmp_key   (key_reg),
        .key_shift (key_shift_reg),
        .act_log2  (act_log2_reg),
        .rd_valid  (rd_valid),
        .rd_key    (rd_key),
        .slot      (probe_slot),
        .sts       (sts)
    );

    // entry count never passes the number of slots
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("entry count above slot count");

    // a nonzero found index only comes with a successful status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (found_index == '0))
        else $error("found index on a failed result");

    // memory is written only by the sweep or by an insert at an empty slot
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SWEEP ||
                    (state_reg == S_CHECK && op_reg == OP_INSERT && !rd_valid)))
        else $error("slot write outside sweep or insert");

endmodule

`default_nettype wire

// ===== tb/dhkim_checker.sv =====
// scoreboard for the key index map: predicts every result from the accepted transactions
module dhkim_checker
    import dhkim_pkg::*;
#(
    parameter int LOG2_SLOTS = 10,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic [1:0]               op,
    input  wire logic [KEY_W-1:0]         key,
    input  wire logic [FIELD_INDEX_W-1:0] elem_index,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic [1:0]               status,
    input  wire logic [FIELD_INDEX_W-1:0] found_index,
    input  wire logic [FIELD_COUNT_W-1:0] count,
    output int                            errors,
    output int                            pending,
    output int                            hits,
    output int                            misses,
    output int                            dups,
    output int                            fulls
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = 1 << LOG2_SLOTS;

    typedef struct packed {
        status_t                  st;
        logic [FIELD_INDEX_W-1:0] idx;
        logic [FIELD_COUNT_W-1:0] cnt;
    } map_result_t;

    // shadow copy of the slot store and registers
    logic                  slot_used   [NUM_SLOTS];
    logic [KEY_W-1:0]      slot_key_q  [NUM_SLOTS];
    logic [INDEX_BITS-1:0] slot_elem_q [NUM_SLOTS];
    int unsigned           entries;
    logic [SHIFT_W-1:0]    shift_reg;
    logic [ACT_W-1:0]      act_reg;

    map_result_t expected_results[$];

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    // one lookup, insert or clear applied to the shadow store
    function automatic map_result_t apply_map_op(logic [1:0] opc, logic [KEY_W-1:0] k,
                                                 logic [FIELD_INDEX_W-1:0] e);
        map_result_t r;
        int unsigned bits;
        int unsigned size;
        int unsigned mask;
        int unsigned pos;
        int unsigned stride;
        int unsigned n;
        logic        done;
        r.st  = STAT_OK;
        r.idx = '0;
        if (opc == OP_CLEAR) begin
            for (n = 0; n < NUM_SLOTS; n++)
                slot_used[n] = 1'b0;
            entries = 0;
        end
        else if (opc == OP_LOOKUP || opc == OP_INSERT) begin
            bits = act_reg;
            if (bits < 1)
                bits = 1;
            if (bits > LOG2_SLOTS)
                bits = LOG2_SLOTS;
            size   = 1 << bits;
            mask   = size - 1;
            pos    = 32'(k >> shift_reg) & mask;
            stride = pos | 1;
            r.st   = (opc == OP_LOOKUP) ? STAT_NOT_FOUND : STAT_FULL;
            done   = 1'b0;
            for (n = 0; n < size && !done; n++) begin
                if (!slot_used[pos]) begin
                    if (opc == OP_INSERT) begin
                        slot_used[pos]   = 1'b1;
                        slot_key_q[pos]  = k;
                        slot_elem_q[pos] = INDEX_BITS'(e);
                        entries++;
                        r.st = STAT_OK;
                    end
                    else
                        r.st = STAT_NOT_FOUND;
                    done = 1'b1;
                end
                else if (slot_key_q[pos] == k) begin
                    if (opc == OP_LOOKUP) begin
                        r.st  = STAT_OK;
                        r.idx = FIELD_INDEX_W'(slot_elem_q[pos]);
                    end
                    else
                        r.st = STAT_DUP;
                    done = 1'b1;
                end
                pos = (pos + stride) & mask;
            end
        end
        r.cnt = FIELD_COUNT_W'(entries);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        map_result_t want;
        if (!rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++)
                slot_used[s] = 1'b0;
            entries   = 0;
            shift_reg = '0;
            act_reg   = ACT_LOG2_RESET;
            expected_results.delete();
            pending <= 0;
        end
        else begin
            // results are checked before this edge's input is predicted
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing outstanding", 64'(status), '0);
                else begin
                    want = expected_results.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 64'(status), 64'(want.st));
                    if (found_index !== want.idx)
                        report_mismatch("found_index", 64'(found_index), 64'(want.idx));
                    if (count !== want.cnt)
                        report_mismatch("count", 64'(count), 64'(want.cnt));
                    case (want.st)
                        STAT_NOT_FOUND: misses++;
                        STAT_DUP:       dups++;
                        STAT_FULL:      fulls++;
                        default:        if (want.idx != 0) hits++;
                    endcase
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_KEY_SHIFT)
                    shift_reg = cfg_data[SHIFT_W-1:0];
                else if (cfg_index == CFG_ACT_LOG2)
                    act_reg = cfg_data[ACT_W-1:0];
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_map_op(op, key, elem_index));
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/double_hash_key_index_map_core_tb.sv =====
// testbench top for the key index map: stimulus, flow control and final verdict
module double_hash_key_index_map_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dhkim_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int MAP_LOG2       = 10;
    localparam int MAP_INDEX_BITS = 16;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int NUM_PHASES     = 12;
    localparam int LONG_HOLD      = 300;
    // slowest correct run stays well under this, even with every table probe maxed
    localparam int CYCLE_LIMIT    = 1_500_000;

    // op code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               op;
    logic [KEY_W-1:0]         key;
    logic [FIELD_INDEX_W-1:0] elem_index;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic [FIELD_INDEX_W-1:0] found_index;
    logic [FIELD_COUNT_W-1:0] count;

    int errors;
    int pending;
    int hits;
    int misses;
    int dups;
    int fulls;

    // flow control knobs, percent of cycles spent idle or stalled
    int send_idle_pct  = 15;
    int recv_stall_pct = 74;
    int long_hold_len  = 0;
    int cycles         = 0;
    int sent_total     = 0;
    int setting_total  = 0;

    // recently inserted keys, reused for hits, duplicates and collisions
    logic [KEY_W-1:0] key_pool[$];

    double_hash_key_index_map_core #(
        .LOG2_SLOTS (MAP_LOG2),
        .INDEX_BITS (MAP_INDEX_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key         (key),
        .elem_index  (elem_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (found_index),
        .count       (count)
    );

    dhkim_checker #(
        .LOG2_SLOTS (MAP_LOG2),
        .INDEX_BITS (MAP_INDEX_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key         (key),
        .elem_index  (elem_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (found_index),
        .count       (count),
        .errors      (errors),
        .pending     (pending),
        .hits        (hits),
        .misses      (misses),
        .dups        (dups),
        .fulls       (fulls)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall, or one long hold-off when asked for
    initial begin
        int span;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_len > 0) begin
                span          = long_hold_len;
                long_hold_len = 0;
                out_stall <= 1'b1;
                repeat (span - 1) @(negedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // offer one input transaction, with random idle cycles ahead of it
    task automatic send_txn(logic [1:0] o, logic [KEY_W-1:0] k, logic [FIELD_INDEX_W-1:0] e);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        key        <= k;
        elem_index <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_total++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        setting_total++;
    endtask

    // stop offering and wait until every outstanding result is back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // key mix: held keys, keys sharing a home slot with a held key, random and extreme keys
    function automatic logic [KEY_W-1:0] pick_key(int sh, int bits);
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(99);
        k = {$urandom, $urandom};
        if (key_pool.size() > 0 && r < 40)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (key_pool.size() > 0 && r < 70)
            k = key_pool[$urandom_range(key_pool.size() - 1)] ^ (k << (sh + bits));
        else if (r < 74)
            k = (r % 2 == 0) ? '0 : '1;
        return k;
    endfunction

    // one random phase: fresh register setting, then a run of mixed transactions
    task automatic run_phase(int phase_no, int items);
        logic [ACT_W-1:0]   act_code;
        logic [SHIFT_W-1:0] sh;
        logic [1:0]         o;
        logic [KEY_W-1:0]   k;
        int                 pick;
        int                 eff_bits;
        settle();
        // receiver-heavy stalling, then sender-heavy idling, then none at all
        if (phase_no < 4) begin
            send_idle_pct  = 15;
            recv_stall_pct = 74;
        end
        else if (phase_no < 8) begin
            send_idle_pct  = 74;
            recv_stall_pct = 15;
        end
        else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        // mostly small tables so that full-table probing stays cheap
        if (phase_no == 5)
            act_code = 4'd10;
        else if (phase_no == 10)
            act_code = 4'd13;
        else
            act_code = ACT_W'($urandom_range(6, 1));
        eff_bits = (act_code == 0) ? 1 : (act_code > MAP_LOG2) ? MAP_LOG2 : int'(act_code);
        sh = SHIFT_W'($urandom_range(31));
        write_reg(CFG_KEY_SHIFT, CFG_DATA_W'(sh));
        write_reg(CFG_ACT_LOG2, CFG_DATA_W'(act_code));
        // other phases keep old entries, some now out of reach
        if (phase_no % 3 == 0 && phase_no != 9)
            send_txn(OP_CLEAR, {$urandom, $urandom}, FIELD_INDEX_W'($urandom));
        // long output hold-off while the sender keeps pushing, fills the pipe
        if (phase_no == 9)
            long_hold_len = LONG_HOLD;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            if (pick < 2)
                o = OP_CLEAR;
            else if (pick < 5)
                o = OP_UNUSED;
            else if (pick < 52)
                o = OP_INSERT;
            else
                o = OP_LOOKUP;
            k = pick_key(sh, eff_bits);
            send_txn(o, k, FIELD_INDEX_W'($urandom));
            if (o == OP_INSERT) begin
                key_pool.push_back(k);
                if (key_pool.size() > 48)
                    void'(key_pool.pop_front());
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        op         = '0;
        key        = '0;
        elem_index = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers still at reset: 256 slots, no shift
        send_txn(OP_LOOKUP, '0, '0);
        settle();

        // two-slot table: fill it, then probe every way past the end
        write_reg(CFG_KEY_SHIFT, 5'd0);
        write_reg(CFG_ACT_LOG2, 5'd1);
        write_reg(CFG_IDX_SPARE_A, 5'd31);
        write_reg(CFG_IDX_SPARE_B, 5'd31);
        send_txn(OP_INSERT, '0, 16'h0000);
        send_txn(OP_INSERT, '1, 16'hFFFF);
        // every probed slot taken
        send_txn(OP_INSERT, 64'd2, 16'h0F0F);
        send_txn(OP_LOOKUP, '0, 16'hFFFF);
        send_txn(OP_LOOKUP, '1, 16'h0000);
        // miss with the whole table occupied
        send_txn(OP_LOOKUP, 64'd2, 16'h0000);
        send_txn(OP_INSERT, '0, 16'h1234);
        send_txn(OP_UNUSED, '1, 16'hFFFF);
        send_txn(OP_CLEAR, '0, 16'h0000);
        send_txn(OP_LOOKUP, '0, 16'h0000);
        settle();

        // active size of zero behaves as one bit
        write_reg(CFG_ACT_LOG2, 5'd0);
        send_txn(OP_INSERT, 64'd5, 16'hA5A5);
        send_txn(OP_INSERT, 64'd7, 16'h5A5A);
        send_txn(OP_LOOKUP, 64'd7, 16'h0000);
        settle();

        // largest shift, oversized active size saturates; old entries stay counted
        write_reg(CFG_KEY_SHIFT, 5'd31);
        write_reg(CFG_ACT_LOG2, 5'd31);
        send_txn(OP_INSERT, 64'hFFFF_FFFF_8000_0000, 16'h8001);
        send_txn(OP_LOOKUP, 64'hFFFF_FFFF_8000_0000, 16'h0000);
        send_txn(OP_INSERT, 64'h8000_0000_0000_0000, 16'h7FFE);
        send_txn(OP_LOOKUP, 64'h8000_0000_0000_0000, 16'h0000);
        send_txn(OP_LOOKUP, 64'h0000_0000_8000_0000, 16'h0000);
        send_txn(OP_CLEAR, '1, 16'hFFFF);

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(p, RANDOM_ITEMS / NUM_PHASES);

        // drain, then leave room for any stray result
        settle();
        repeat (64) @(posedge clk);

        $display("ran %0d transactions over %0d register writes, idle mixes and a long hold",
                 sent_total, setting_total);
        $display("hits %0d, misses %0d, duplicates %0d, table full %0d",
                 hits, misses, dups, fulls);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
